@@ rtl/ceoc_pkg.sv @@
// Shared constants, codes and control types of the circle edge overlap counter.
package ceoc_pkg;

    // Edge map dimensions.
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;

    localparam int X_W      = $clog2(MAX_WIDTH);
    localparam int Y_W      = $clog2(MAX_HEIGHT);
    localparam int ADDR_W   = X_W + Y_W;
    localparam int MAP_DEPTH = 2 ** ADDR_W;

    // Coordinates are signed and must hold both the circle points and the image bounds.
    localparam int MAX_DIM  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DIM_BITS = $clog2(MAX_DIM + 1);
    localparam int COORD_W  = (DIM_BITS + 1 > 12) ? DIM_BITS + 1 : 12;

    // Walk variables (dx, dy, error term and its increments) fit in 12 signed bits.
    localparam int WALK_W = 12;

    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam int COUNT_W   = 12;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [CFG_W-1:0]   CFG_RESET = 9'd256;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_IN_USE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_IN_USE = 1'b1;

    // Request codes.
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;      // latch the beat and reset the walk and the counts
        logic map_write;  // write the pixel flag of a load beat
        logic step;       // probe the current octant point and advance
        logic capture;    // move the counts into the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic walk_go;      // dx >= dy
        logic point_first;  // next probe is the first of a step
    } status_t;

endpackage

@@ rtl/circle_edge_overlap_counter_unit.sv @@
// Top level of the circle edge overlap counter: controller and datapath.
//
// The block keeps a one-bit edge map of 256 by 256 pixels and answers circle
// queries against it. A load beat (req_type 0) stores whether pixel_value is
// nonzero at (pixel_x, pixel_y) and returns a result beat with both counts zero.
// A query beat (req_type 1) walks the midpoint circle of the given centre and
// radius while dx is at least dy and probes the eight octant points of every
// step, one point per cycle through the single read port of the edge map.
// Points outside the image size set by the width and height registers are
// skipped; total_count gives the points inside and overlap_count those whose
// stored flag is set, both saturating at 4095. Every pixel that a query reads
// must have been loaded beforehand. The result sits in an output register, so
// the next beat is taken while a result still waits. Configuration writes are to
// be made only while the block is idle; the block itself does not enforce this.
module circle_edge_overlap_counter_unit
(
    input  logic                           clk,
    input  logic                           rst_n,

    // Configuration write port.
    input  logic                           cfg_we,
    input  logic [ceoc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ceoc_pkg::CFG_W-1:0]     cfg_data,

    // Input channel.
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           req_type,
    input  logic [7:0]                     pixel_x,
    input  logic [7:0]                     pixel_y,
    input  logic [7:0]                     pixel_value,
    input  logic signed [9:0]              center_x,
    input  logic signed [9:0]              center_y,
    input  logic [8:0]                     radius,

    // Output channel.
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ceoc_pkg::COUNT_W-1:0]   total_count,
    output logic [ceoc_pkg::COUNT_W-1:0]   overlap_count
);

    ceoc_pkg::cmd_t    cmd;
    ceoc_pkg::status_t status;

    // The controller sequences load, walk and hand-over of one beat at a time.
    ceoc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds the map, the walk registers, the counters and the result.
    ceoc_dpath u_dpath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .pixel_value   (pixel_value),
        .center_x      (center_x),
        .center_y      (center_y),
        .radius        (radius),
        .cmd           (cmd),
        .status        (status),
        .total_count   (total_count),
        .overlap_count (overlap_count)
    );

endmodule

@@ rtl/ceoc_ctrl.sv @@
// Controller state machine of the circle edge overlap counter.
module ceoc_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              req_type,
    output logic              out_valid,
    input  logic              out_ready,
    input  ceoc_pkg::status_t status,
    output ceoc_pkg::cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        in_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start     = 1'b1;
                    cmd.map_write = (req_type == ceoc_pkg::REQ_LOAD);
                    state_next    = (req_type == ceoc_pkg::REQ_QUERY) ? ST_WALK : ST_FIN;
                end
            end
            ST_WALK:
            begin
                if (status.point_first && !status.walk_go)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = cmd.capture ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ rtl/ceoc_dpath.sv @@
// Datapath of the circle edge overlap counter: edge map, circle walk and counters.
module ceoc_dpath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ceoc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ceoc_pkg::CFG_W-1:0]          cfg_data,
    input  logic [7:0]                          pixel_x,
    input  logic [7:0]                          pixel_y,
    input  logic [7:0]                          pixel_value,
    input  logic signed [9:0]                   center_x,
    input  logic signed [9:0]                   center_y,
    input  logic [8:0]                          radius,
    input  ceoc_pkg::cmd_t                      cmd,
    output ceoc_pkg::status_t                   status,
    output logic [ceoc_pkg::COUNT_W-1:0]        total_count,
    output logic [ceoc_pkg::COUNT_W-1:0]        overlap_count
);

    localparam int CW = ceoc_pkg::COORD_W;
    localparam int WW = ceoc_pkg::WALK_W;
    localparam int NW = ceoc_pkg::COUNT_W;

    // Configuration.
    logic [ceoc_pkg::CFG_W-1:0] width_reg;
    logic [ceoc_pkg::CFG_W-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= ceoc_pkg::CFG_RESET;
            height_reg <= ceoc_pkg::CFG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ceoc_pkg::CFG_WIDTH_IN_USE:  width_reg  <= cfg_data;
                ceoc_pkg::CFG_HEIGHT_IN_USE: height_reg <= cfg_data;
                default:                     ;
            endcase
        end
    end

    logic [CW-1:0] w_wide;
    logic [CW-1:0] h_wide;
    logic [CW-1:0] w_eff;
    logic [CW-1:0] h_eff;

    assign w_wide = CW'(width_reg);
    assign h_wide = CW'(height_reg);
    assign w_eff  = (w_wide > CW'(ceoc_pkg::MAX_WIDTH))  ? CW'(ceoc_pkg::MAX_WIDTH)  : w_wide;
    assign h_eff  = (h_wide > CW'(ceoc_pkg::MAX_HEIGHT)) ? CW'(ceoc_pkg::MAX_HEIGHT) : h_wide;

    // Walk state.
    logic signed [CW-1:0] cx_reg, cx_next;
    logic signed [CW-1:0] cy_reg, cy_next;
    logic signed [WW-1:0] dx_reg, dx_next;
    logic signed [WW-1:0] dy_reg, dy_next;
    logic signed [WW-1:0] err_reg, err_next;
    logic signed [WW-1:0] plus_reg, plus_next;
    logic signed [WW-1:0] minus_reg, minus_next;
    logic [2:0]           pt_reg, pt_next;
    logic signed [WW-1:0] err_sum;

    // Probe point of the current octant index.
    logic signed [WW-1:0] off_x;
    logic signed [WW-1:0] off_y;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic                 in_image;
    logic [ceoc_pkg::ADDR_W-1:0] rd_addr;

    assign off_x = pt_reg[2] ? dy_reg : dx_reg;
    assign off_y = pt_reg[2] ? dx_reg : dy_reg;
    assign px    = pt_reg[1] ? (cx_reg + CW'(off_x)) : (cx_reg - CW'(off_x));
    assign py    = pt_reg[0] ? (cy_reg + CW'(off_y)) : (cy_reg - CW'(off_y));
    assign in_image = (px >= 0) && (px < $signed(w_eff)) && (py >= 0) && (py < $signed(h_eff));
    assign rd_addr  = {py[ceoc_pkg::Y_W-1:0], px[ceoc_pkg::X_W-1:0]};

    assign err_sum = err_reg + plus_reg;

    always_comb
    begin
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        err_next   = err_reg;
        plus_next  = plus_reg;
        minus_next = minus_reg;
        pt_next    = pt_reg;
        if (cmd.start)
        begin
            cx_next    = CW'(center_x);
            cy_next    = CW'(center_y);
            dx_next    = $signed(WW'(radius));
            dy_next    = '0;
            err_next   = '0;
            plus_next  = WW'(1);
            minus_next = $signed(WW'({radius, 1'b0})) - WW'(1);
            pt_next    = '0;
        end
        else if (cmd.step)
        begin
            pt_next = pt_reg + 3'd1;
            if (pt_reg == 3'd7)
            begin
                dy_next   = dy_reg + WW'(1);
                plus_next = plus_reg + WW'(2);
                if (err_sum > 0)
                begin
                    err_next   = err_sum - minus_reg;
                    dx_next    = dx_reg - WW'(1);
                    minus_next = minus_reg - WW'(2);
                end
                else
                begin
                    err_next = err_sum;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        err_reg   <= err_next;
        plus_reg  <= plus_next;
        minus_reg <= minus_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pt_reg <= '0;
        end
        else
        begin
            pt_reg <= pt_next;
        end
    end

    assign status.walk_go     = (dx_reg >= dy_reg);
    assign status.point_first = (pt_reg == 3'd0);

    // Edge map: one write port for loads, one registered read port for probes.
    logic map_mem [0:ceoc_pkg::MAP_DEPTH-1];
    logic rd_flag_reg;
    logic wr_ok;
    logic [ceoc_pkg::ADDR_W-1:0] wr_addr;

    assign wr_ok = (CW'(pixel_x) < CW'(ceoc_pkg::MAX_WIDTH))
                && (CW'(pixel_y) < CW'(ceoc_pkg::MAX_HEIGHT));
    assign wr_addr = {ceoc_pkg::Y_W'(pixel_y), ceoc_pkg::X_W'(pixel_x)};

    always_ff @(posedge clk)
    begin
        if (cmd.map_write && wr_ok)
        begin
            map_mem[wr_addr] <= (pixel_value != 8'd0);
        end
        rd_flag_reg <= map_mem[rd_addr];
    end

    // Counting stage, in the cycle after the probe.
    logic probe_valid_reg;
    logic probe_valid_next;
    logic [NW-1:0] tot_reg, tot_next;
    logic [NW-1:0] hit_reg, hit_next;

    assign probe_valid_next = cmd.step && in_image;

    always_comb
    begin
        tot_next = tot_reg;
        hit_next = hit_reg;
        if (cmd.start)
        begin
            tot_next = '0;
            hit_next = '0;
        end
        else if (probe_valid_reg)
        begin
            if (tot_reg != ceoc_pkg::COUNT_MAX)
            begin
                tot_next = tot_reg + NW'(1);
            end
            if (rd_flag_reg && (hit_reg != ceoc_pkg::COUNT_MAX))
            begin
                hit_next = hit_reg + NW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_valid_reg <= 1'b0;
        end
        else
        begin
            probe_valid_reg <= probe_valid_next;
        end
    end

    // Output payload register.
    logic [NW-1:0] total_out_reg;
    logic [NW-1:0] overlap_out_reg;

    always_ff @(posedge clk)
    begin
        tot_reg <= tot_next;
        hit_reg <= hit_next;
        if (cmd.capture)
        begin
            total_out_reg   <= tot_reg;
            overlap_out_reg <= hit_reg;
        end
    end

    assign total_count   = total_out_reg;
    assign overlap_count = overlap_out_reg;

endmodule

@@ dv/tb_circle_edge_overlap_counter_unit.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the circle edge overlap counter: stimulus, prediction and checks.
module tb_circle_edge_overlap_counter_unit;

    // One input beat, as it is presented on the input channel. The load fields are
    // don't-care on a query beat and the query fields on a load beat; both are filled
    // with random values so that every port bit toggles.
    typedef struct {
        logic              kind;
        logic [7:0]        px;
        logic [7:0]        py;
        logic [7:0]        pv;
        logic signed [9:0] cx;
        logic signed [9:0] cy;
        logic [8:0]        rad;
    } pixel_beat_t;

    // The two counts that the block returns for every input beat.
    typedef struct packed {
        logic [ceoc_pkg::COUNT_W-1:0] total;
        logic [ceoc_pkg::COUNT_W-1:0] overlap;
    } circle_tally_t;

    localparam int MAP_ENTRIES = ceoc_pkg::MAX_WIDTH * ceoc_pkg::MAX_HEIGHT;

    // A query may only be issued once every in-image point it touches has been
    // loaded. This is how many missing pixels a random query may pull in.
    localparam int LOAD_BUDGET = 64;

    // Number of random beats per size setting.
    localparam int PHASE_BEATS = 128;

    logic clk;
    logic rst_n = 1'b0;

    logic                           cfg_we    = 1'b0;
    logic [ceoc_pkg::CFG_IDX_W-1:0] cfg_index = ceoc_pkg::CFG_WIDTH_IN_USE;
    logic [ceoc_pkg::CFG_W-1:0]     cfg_data  = '0;

    logic              in_valid    = 1'b0;
    logic              in_ready;
    logic              req_type    = ceoc_pkg::REQ_LOAD;
    logic [7:0]        pixel_x     = '0;
    logic [7:0]        pixel_y     = '0;
    logic [7:0]        pixel_value = '0;
    logic signed [9:0] center_x    = '0;
    logic signed [9:0] center_y    = '0;
    logic [8:0]        radius      = '0;

    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [ceoc_pkg::COUNT_W-1:0] total_count;
    logic [ceoc_pkg::COUNT_W-1:0] overlap_count;

    // Predictor state: our own copy of the edge map and of the two size registers.
    bit                   edge_flags [0:MAP_ENTRIES-1];
    logic [8:0]           model_width;
    logic [8:0]           model_height;

    // Stimulus bookkeeping: which pixels have been loaded by beats already queued.
    bit                   pixel_loaded [0:MAP_ENTRIES-1];

    pixel_beat_t          pending_beats [$];
    circle_tally_t        expected_tallies [$];
    pixel_beat_t          active_beat;

    int                   beats_outstanding = 0;
    int                   loads_queued      = 0;
    int                   queries_queued    = 0;
    int                   results_checked   = 0;
    int                   fault_count       = 0;
    int                   settings_used     = 1;
    int                   send_gap          = 0;
    int                   recv_stall        = 0;
    bit                   send_burst        = 1'b0;
    bit                   recv_burst        = 1'b0;
    longint               cycle_count       = 0;
    longint               cycle_limit       = 200000;

    circle_edge_overlap_counter_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .pixel_value   (pixel_value),
        .center_x      (center_x),
        .center_y      (center_y),
        .radius        (radius),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .total_count   (total_count),
        .overlap_count (overlap_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // A size register above the map dimension behaves as the map dimension.
    function automatic int effective_size(input logic [8:0] reg_value, input int cap);
        return (int'(reg_value) > cap) ? cap : int'(reg_value);
    endfunction

    // Walks the midpoint circle for as long as dx is at least dy and collects the map
    // address of every octant point that falls inside the image. Points that coincide
    // (on the axes, the diagonals, or all eight at radius zero) are collected each time.
    function automatic void trace_circle_points(input int cx, input int cy, input int r,
                                                input int w, input int h,
                                                output int points [$]);
        int err;
        int dx;
        int dy;
        int plus;
        int minus;
        int xs [8];
        int ys [8];
        points = {};
        err    = 0;
        dx     = r;
        dy     = 0;
        plus   = 1;
        minus  = 2 * r - 1;
        while (dx >= dy)
        begin
            xs = '{cx - dx, cx - dx, cx + dx, cx + dx, cx - dy, cx - dy, cx + dy, cx + dy};
            ys = '{cy - dy, cy + dy, cy - dy, cy + dy, cy - dx, cy + dx, cy - dx, cy + dx};
            for (int k = 0; k < 8; k++)
            begin
                if (xs[k] >= 0 && xs[k] < w && ys[k] >= 0 && ys[k] < h)
                    points = {points, ys[k] * ceoc_pkg::MAX_WIDTH + xs[k]};
            end
            dy++;
            err  += plus;
            plus += 2;
            if (err > 0)
            begin
                err   -= minus;
                dx--;
                minus -= 2;
            end
        end
    endfunction

    // Applies one accepted beat to the predicted state and returns the counts that the
    // block must answer with. A load stores the nonzero flag and answers with zeros.
    function automatic circle_tally_t apply_beat(input pixel_beat_t b);
        circle_tally_t tally;
        int            points [$];
        tally = '0;
        if (b.kind == ceoc_pkg::REQ_LOAD)
        begin
            edge_flags[int'(b.py) * ceoc_pkg::MAX_WIDTH + int'(b.px)] = (b.pv != 8'd0);
        end
        else
        begin
            trace_circle_points(int'(b.cx), int'(b.cy), int'(b.rad),
                                effective_size(model_width, ceoc_pkg::MAX_WIDTH),
                                effective_size(model_height, ceoc_pkg::MAX_HEIGHT),
                                points);
            foreach (points[k])
            begin
                if (tally.total != ceoc_pkg::COUNT_MAX)
                    tally.total = tally.total + 1'b1;
                if (edge_flags[points[k]] && tally.overlap != ceoc_pkg::COUNT_MAX)
                    tally.overlap = tally.overlap + 1'b1;
            end
        end
        return tally;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------

    // Draws the idle time before the next beat on one side. Now and then the side
    // switches into or out of a burst, during which it never idles.
    function automatic int draw_wait(inout bit burst);
        if ($urandom_range(0, 15) == 0)
            burst = !burst;
        return burst ? 0 : int'($urandom_range(0, 15));
    endfunction

    // Half the pixel bytes are zero so that the map holds both flags in equal measure.
    function automatic logic [7:0] draw_pixel_byte();
        unique case ($urandom_range(0, 5))
            0, 1, 2: return 8'd0;
            3:       return 8'hFF;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    task automatic queue_load(input int x, input int y, input logic [7:0] value);
        pixel_beat_t b;
        b.kind = ceoc_pkg::REQ_LOAD;
        b.px   = 8'(x);
        b.py   = 8'(y);
        b.pv   = value;
        b.cx   = 10'($urandom);
        b.cy   = 10'($urandom);
        b.rad  = 9'($urandom);
        pending_beats = {pending_beats, b};
        pixel_loaded[y * ceoc_pkg::MAX_WIDTH + x] = 1'b1;
        beats_outstanding++;
        loads_queued++;
        cycle_limit += 4 * 80;
    endtask

    // Counts the in-image points of a candidate query that nobody has loaded yet.
    function automatic int unloaded_points(input int cx, input int cy, input int r,
                                           input int w, input int h);
        int points [$];
        int missing;
        missing = 0;
        trace_circle_points(cx, cy, r, w, h, points);
        foreach (points[k])
        begin
            if (!pixel_loaded[points[k]])
                missing++;
        end
        return missing;
    endfunction

    // Queues a query, preceded by loads of every in-image pixel it would otherwise read
    // before that pixel was ever written.
    task automatic queue_query(input int cx, input int cy, input int r);
        pixel_beat_t b;
        int          points [$];
        trace_circle_points(cx, cy, r, effective_size(model_width, ceoc_pkg::MAX_WIDTH),
                            effective_size(model_height, ceoc_pkg::MAX_HEIGHT), points);
        foreach (points[k])
        begin
            if (!pixel_loaded[points[k]])
                queue_load(points[k] % ceoc_pkg::MAX_WIDTH, points[k] / ceoc_pkg::MAX_WIDTH,
                           draw_pixel_byte());
        end
        b.kind = ceoc_pkg::REQ_QUERY;
        b.px   = 8'($urandom);
        b.py   = 8'($urandom);
        b.pv   = 8'($urandom);
        b.cx   = 10'(cx);
        b.cy   = 10'(cy);
        b.rad  = 9'(r);
        pending_beats = {pending_beats, b};
        beats_outstanding++;
        queries_queued++;
        cycle_limit += 4 * (8 * (r + 1) + 80);
    endtask

    // Most radii are small to keep the run short; a few reach into the top bit.
    // Centres mostly sit around the image so that the circles cross its edges,
    // the rest anywhere in the signed range.
    task automatic queue_random_query();
        int sel;
        int r;
        int w;
        int h;
        int cx;
        int cy;
        bit placed;
        sel = int'($urandom_range(0, 99));
        if (sel < 60)
            r = int'($urandom_range(0, 15));
        else if (sel < 85)
            r = int'($urandom_range(16, 63));
        else if (sel < 95)
            r = int'($urandom_range(64, 255));
        else
            r = int'($urandom_range(256, 511));
        w      = effective_size(model_width, ceoc_pkg::MAX_WIDTH);
        h      = effective_size(model_height, ceoc_pkg::MAX_HEIGHT);
        placed = 1'b0;
        cx     = -512;
        cy     = -512;
        for (int attempt = 0; attempt < 8 && !placed; attempt++)
        begin
            if (w > 0 && h > 0 && $urandom_range(0, 9) < 7)
            begin
                cx = int'($urandom_range(0, w + 2 * r + 3)) - r - 2;
                cy = int'($urandom_range(0, h + 2 * r + 3)) - r - 2;
                cx = (cx > 511) ? 511 : cx;
                cy = (cy > 511) ? 511 : cy;
                cx = (cx < -512) ? -512 : cx;
                cy = (cy < -512) ? -512 : cy;
            end
            else
            begin
                cx = int'($urandom_range(0, 1023)) - 512;
                cy = int'($urandom_range(0, 1023)) - 512;
            end
            placed = (unloaded_points(cx, cy, r, w, h) <= LOAD_BUDGET);
        end
        // A corner centre keeps every point of any radius off the image.
        if (!placed)
        begin
            cx = -512;
            cy = -512;
        end
        queue_query(cx, cy, r);
    endtask

    // One stretch of random traffic: mostly queries with the loads they need, the
    // rest stray loads anywhere in the map, rewrites of old pixels among them.
    task automatic run_random_phase(input int beats);
        int first;
        first = loads_queued + queries_queued;
        while (loads_queued + queries_queued - first < beats)
        begin
            if ($urandom_range(0, 4) == 0)
                queue_load(int'($urandom_range(0, 255)), int'($urandom_range(0, 255)),
                           draw_pixel_byte());
            else
                queue_random_query();
        end
    endtask

    // The block is idle once every queued beat has had its result beat.
    task automatic wait_for_idle();
        while (beats_outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Both size registers are written back to back, only while the block is idle.
    task automatic write_sizes(input int w, input int h);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= ceoc_pkg::CFG_WIDTH_IN_USE;
        cfg_data  <= ceoc_pkg::CFG_W'(w);
        @(posedge clk);
        cfg_index <= ceoc_pkg::CFG_HEIGHT_IN_USE;
        cfg_data  <= ceoc_pkg::CFG_W'(h);
        @(posedge clk);
        cfg_we    <= 1'b0;
        model_width  = 9'(w);
        model_height = 9'(h);
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // Input side: presents queued beats with random idle gaps and predicts the
    // result of each beat at the edge where it is accepted.
    // ------------------------------------------------------------------
    task automatic present_beat(input pixel_beat_t b);
        req_type    <= b.kind;
        pixel_x     <= b.px;
        pixel_y     <= b.py;
        pixel_value <= b.pv;
        center_x    <= b.cx;
        center_y    <= b.cy;
        radius      <= b.rad;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : input_side
        int gap;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else if (in_valid && in_ready)
        begin
            expected_tallies = {expected_tallies, apply_beat(active_beat)};
            gap = draw_wait(send_burst);
            // With no gap the next beat follows straight on and valid stays high.
            if (gap == 0 && pending_beats.size() != 0)
            begin
                active_beat = pending_beats.pop_front();
                present_beat(active_beat);
            end
            else
            begin
                in_valid <= 1'b0;
                send_gap <= gap;
            end
        end
        else if (!in_valid)
        begin
            if (send_gap != 0)
                send_gap <= send_gap - 1;
            else if (pending_beats.size() != 0)
            begin
                active_beat = pending_beats.pop_front();
                present_beat(active_beat);
                in_valid <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output side: stalls each result beat for a random number of cycles and
    // compares every accepted result with the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : output_side
        int            stall;
        circle_tally_t want;
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            recv_stall <= 0;
        end
        else if (out_valid && out_ready)
        begin
            if (expected_tallies.size() == 0)
            begin
                $error("result beat with nothing expected: total_count %0d, overlap_count %0d",
                       total_count, overlap_count);
                fault_count++;
            end
            else
            begin
                want = expected_tallies.pop_front();
                beats_outstanding--;
                results_checked++;
                if (total_count !== want.total)
                begin
                    $error("total_count mismatch: expected %0d, actual %0d",
                           want.total, total_count);
                    fault_count++;
                end
                if (overlap_count !== want.overlap)
                begin
                    $error("overlap_count mismatch: expected %0d, actual %0d",
                           want.overlap, overlap_count);
                    fault_count++;
                end
            end
            stall = draw_wait(recv_burst);
            if (stall != 0)
            begin
                out_ready  <= 1'b0;
                recv_stall <= stall;
            end
        end
        else if (!out_ready)
        begin
            // The stall is counted in cycles during which a result is actually waiting.
            if (recv_stall == 0)
                out_ready <= 1'b1;
            else if (out_valid)
                recv_stall <= recv_stall - 1;
        end
    end

    // Watchdog: the limit grows with every queued beat, reckoned from its worst case.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > cycle_limit)
        begin
            $display("circle_edge_overlap_counter_unit regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence of the run.
    // ------------------------------------------------------------------
    initial
    begin : sequencer
        int widths  [8];
        int heights [8];
        model_width  = ceoc_pkg::CFG_RESET;
        model_height = ceoc_pkg::CFG_RESET;

        // Directed beats at the reset image size of 256 by 256. They are queued during
        // reset and go out as soon as it is released.
        queue_load(0, 0, 8'hFF);
        queue_load(255, 255, 8'h01);
        queue_load(255, 0, 8'h00);
        queue_load(0, 255, 8'h80);
        queue_load(128, 64, 8'h7F);
        // Radius zero: all eight points land on the centre and are counted each time.
        queue_query(0, 0, 0);
        queue_query(255, 255, 0);
        queue_query(255, 0, 0);
        queue_query(128, 64, 0);
        // A rewrite clears the flag, so the same query now overlaps nothing.
        queue_load(128, 64, 8'h00);
        queue_query(128, 64, 0);
        // Centres off the image and the extremes of the signed range and the radius.
        queue_query(-1, -1, 0);
        queue_query(-512, -512, 511);
        queue_query(511, -512, 511);
        queue_query(511, 511, 300);
        // Small circles clipped by the image edges, with the loads they need.
        queue_query(0, 255, 1);
        queue_query(255, 128, 2);
        queue_query(100, 100, 3);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        run_random_phase(PHASE_BEATS);
        wait_for_idle();

        // Size settings: empty image, single pixel, narrow and flat strips, values
        // beyond the map that saturate, then random ones, and back to the full map.
        widths  = '{0, 1, 8, 511, 256, 1, 0, 256};
        heights = '{0, 1, 256, 300, 1, 1, 0, 256};
        widths[5]  = int'($urandom_range(1, 256));
        heights[5] = int'($urandom_range(1, 256));
        widths[6]  = int'($urandom_range(0, 511));
        heights[6] = int'($urandom_range(0, 511));
        for (int p = 0; p < 8; p++)
        begin
            write_sizes(widths[p], heights[p]);
            run_random_phase(PHASE_BEATS);
            wait_for_idle();
        end

        repeat (16) @(posedge clk);
        $display("Covered %0d pixel loads and %0d circle queries under %0d image sizes.",
                 loads_queued, queries_queued, settings_used);
        $display("Compared %0d result beats; %0d faults found.", results_checked, fault_count);
        if (fault_count == 0 && expected_tallies.size() == 0)
            $display("circle_edge_overlap_counter_unit regression: pass");
        else
            $display("circle_edge_overlap_counter_unit regression: fail");
        $finish;
    end

endmodule
